// ----- src/pwl_pkg.sv -----
package pwl_pkg;

	// Table geometry.
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int DATA_W      = 32;
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	// Operation codes.
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] key_in;
		logic signed [DATA_W-1:0] value_in;
	} pwl_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic [1:0]               status;
	} pwl_rsp_t;

	// One breakpoint as stored in the table memory.
	typedef struct packed {
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} pwl_entry_t;

	// Write request into the table memory.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		pwl_entry_t       data;
	} pwl_mem_wr_t;

endpackage

// ----- src/pwl_mem.sv -----
module pwl_mem (
	input  logic                      clk,
	input  pwl_pkg::pwl_mem_wr_t      wr,
	input  logic [pwl_pkg::IDX_W-1:0] rd_addr,
	output pwl_pkg::pwl_entry_t       rd_data
);

	pwl_pkg::pwl_entry_t mem [pwl_pkg::MAX_ENTRIES];
	pwl_pkg::pwl_entry_t rd_data_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Single registered read port.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/pwl_div.sv -----
module pwl_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [2*pwl_pkg::DATA_W-1:0]     dividend,
	input  logic [pwl_pkg::DATA_W-1:0]       divisor,
	output logic                             done,
	output logic [pwl_pkg::DATA_W-1:0]       quotient
);

	// Restoring division, one quotient bit per cycle. The caller guarantees
	// that the quotient fits in DATA_W bits, so the upper half of the
	// dividend is already below the divisor and seeds the remainder.
	logic                             busy_q;
	logic                             done_q;
	logic [pwl_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [pwl_pkg::DATA_W-1:0]       rem_q;
	logic [pwl_pkg::DATA_W-1:0]       lo_q;
	logic [pwl_pkg::DATA_W-1:0]       den_q;
	logic [pwl_pkg::DATA_W-1:0]       quo_q;
	logic [pwl_pkg::DATA_W+1:0]       trial;

	assign trial = {1'b0, rem_q, lo_q[pwl_pkg::DATA_W-1]} - {2'b00, den_q};

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == pwl_pkg::DIV_CNT_W'(pwl_pkg::DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: shift in one dividend bit and try a subtraction.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[2*pwl_pkg::DATA_W-1:pwl_pkg::DATA_W];
			lo_q  <= dividend[pwl_pkg::DATA_W-1:0];
			den_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			lo_q <= {lo_q[pwl_pkg::DATA_W-2:0], 1'b0};
			if (!trial[pwl_pkg::DATA_W+1]) begin
				rem_q <= trial[pwl_pkg::DATA_W-1:0];
				quo_q <= {quo_q[pwl_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[pwl_pkg::DATA_W-2:0], lo_q[pwl_pkg::DATA_W-1]};
				quo_q <= {quo_q[pwl_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- src/piecewise_linear_lookup_core.sv -----
// Piecewise-linear lookup core.
// The request channel (req_valid, req_ready, req) carries one operation: clear,
// insert a key/value breakpoint, or query an interpolated value. Every request
// yields exactly one response on the response channel (rsp_valid, rsp_ready,
// rsp) carrying the signed Q16.16 result and a status code.
// Requests are handled one at a time; req_ready is high only while idle.
// Breakpoints live in a table memory with one write and one registered read
// port. An insert shift step costs a read and a check; a query scan step is a
// single pass through S_Q_SCAN.
// Clear, no-op, full insert and empty query go straight to the response. An
// insert moves the entries above its key up one slot, top entry first. A query
// compares against the first and last entries to clamp, else scans for the
// bracket, multiplies and runs the serial divider; the sum saturates.
// A new request can transfer once the previous response has registered.
// Reset clears the entry count and the control state; the table contents are
// left as they are and are never read before being written.
// A stalled response holds in the output register; the next request is still
// taken, and its result waits with req_ready low until that response transfers.
module piecewise_linear_lookup_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  pwl_pkg::pwl_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output pwl_pkg::pwl_rsp_t rsp
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CHK,
		S_INS_PUT0,
		S_Q_RD0,
		S_Q_FIRST,
		S_Q_LAST,
		S_Q_SCAN,
		S_MUL,
		S_DIV_GO,
		S_DIV_WAIT,
		S_EMIT
	} state_t;

	state_t                            state_q;
	logic [pwl_pkg::CNT_W-1:0]         count_q;
	logic [pwl_pkg::IDX_W-1:0]         j_q;
	logic [pwl_pkg::IDX_W-1:0]         i_q;
	logic signed [pwl_pkg::DATA_W-1:0] key_q;
	logic signed [pwl_pkg::DATA_W-1:0] val_q;
	pwl_pkg::pwl_entry_t               prev_q;
	logic [pwl_pkg::DATA_W-1:0]        dq_q;
	logic [pwl_pkg::DATA_W-1:0]        den_q;
	logic [pwl_pkg::DATA_W-1:0]        dv_q;
	logic                              neg_q;
	logic signed [pwl_pkg::DATA_W-1:0] v0_q;
	logic [2*pwl_pkg::DATA_W-1:0]      prod_q;
	logic signed [pwl_pkg::DATA_W-1:0] res_q;
	logic [1:0]                        st_q;
	logic                              rsp_valid_q;
	pwl_pkg::pwl_rsp_t                 rsp_q;

	pwl_pkg::pwl_mem_wr_t              mem_wr;
	logic [pwl_pkg::IDX_W-1:0]         mem_rd_addr;
	pwl_pkg::pwl_entry_t               mem_rd;
	logic                              div_start;
	logic                              div_done;
	logic [pwl_pkg::DATA_W-1:0]        div_quot;
	logic [pwl_pkg::CNT_W-1:0]         last_idx;
	logic signed [pwl_pkg::DATA_W+1:0] sum;
	logic                              slot_free;
	logic                              req_xfer;

	assign req_ready = (state_q == S_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign last_idx  = count_q - 1'b1;
	assign div_start = (state_q == S_DIV_GO);

	pwl_mem u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd)
	);

	pwl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Read address for the entry examined in the following cycle.
	always_comb begin
		unique case (state_q)
			S_INS_RD:  mem_rd_addr = j_q - 1'b1;
			S_Q_FIRST: mem_rd_addr = last_idx[pwl_pkg::IDX_W-1:0];
			S_Q_LAST:  mem_rd_addr = pwl_pkg::IDX_W'(1);
			S_Q_SCAN:  mem_rd_addr = i_q + 1'b1;
			default:   mem_rd_addr = '0;
		endcase
	end

	// Table writes: either an entry moves up one slot or the new pair lands.
	always_comb begin
		mem_wr.en         = 1'b0;
		mem_wr.addr       = j_q;
		mem_wr.data.key   = key_q;
		mem_wr.data.value = val_q;
		if (state_q == S_INS_PUT0) begin
			mem_wr.en = 1'b1;
		end else if (state_q == S_INS_CHK) begin
			mem_wr.en = 1'b1;
			if (mem_rd.key > key_q) begin
				mem_wr.data = mem_rd;
			end
		end
	end

	// Final sum of the interpolation, one bit wider on each side for saturation.
	always_comb begin
		if (neg_q) begin
			sum = 34'(v0_q) - $signed({2'b00, div_quot});
		end else begin
			sum = 34'(v0_q) + $signed({2'b00, div_quot});
		end
	end

	// Sequencer and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						key_q <= req.key_in;
						val_q <= req.value_in;
						res_q <= '0;
						st_q  <= pwl_pkg::ST_OK;
						j_q   <= count_q[pwl_pkg::IDX_W-1:0];
						state_q <= S_EMIT;
						priority if (req.op == pwl_pkg::OP_CLEAR) begin
							count_q <= '0;
						end else if (req.op == pwl_pkg::OP_INSERT) begin
							if (count_q == pwl_pkg::CNT_W'(pwl_pkg::MAX_ENTRIES)) begin
								st_q <= pwl_pkg::ST_FULL;
							end else if (count_q == '0) begin
								state_q <= S_INS_PUT0;
							end else begin
								state_q <= S_INS_RD;
							end
						end else if (req.op == pwl_pkg::OP_QUERY) begin
							if (count_q == '0) begin
								st_q <= pwl_pkg::ST_EMPTY;
							end else begin
								state_q <= S_Q_RD0;
							end
						end else begin
							// The unused code leaves the table as it is.
						end
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CHK;
				end
				S_INS_CHK: begin
					// An entry not above the new key marks the insert position.
					if (mem_rd.key <= key_q) begin
						count_q <= count_q + 1'b1;
						state_q <= S_EMIT;
					end else begin
						j_q <= j_q - 1'b1;
						state_q <= (j_q == pwl_pkg::IDX_W'(1)) ? S_INS_PUT0 : S_INS_RD;
					end
				end
				S_INS_PUT0: begin
					count_q <= count_q + 1'b1;
					state_q <= S_EMIT;
				end
				S_Q_RD0: begin
					state_q <= S_Q_FIRST;
				end
				S_Q_FIRST: begin
					// Clamp below the first key.
					if (key_q <= mem_rd.key) begin
						res_q   <= mem_rd.value;
						state_q <= S_EMIT;
					end else begin
						prev_q  <= mem_rd;
						state_q <= S_Q_LAST;
					end
				end
				S_Q_LAST: begin
					// Clamp above the last key.
					if (key_q >= mem_rd.key) begin
						res_q   <= mem_rd.value;
						state_q <= S_EMIT;
					end else begin
						i_q     <= pwl_pkg::IDX_W'(1);
						state_q <= S_Q_SCAN;
					end
				end
				S_Q_SCAN: begin
					// The first key at or above the query closes the bracket.
					if (key_q <= mem_rd.key) begin
						dq_q    <= key_q - prev_q.key;
						den_q   <= mem_rd.key - prev_q.key;
						neg_q   <= mem_rd.value < prev_q.value;
						dv_q    <= (mem_rd.value < prev_q.value) ?
							(prev_q.value - mem_rd.value) : (mem_rd.value - prev_q.value);
						v0_q    <= prev_q.value;
						state_q <= S_MUL;
					end else begin
						prev_q <= mem_rd;
						i_q    <= i_q + 1'b1;
					end
				end
				S_MUL: begin
					prod_q  <= dq_q * dv_q;
					state_q <= S_DIV_GO;
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						priority if (sum > 34'sh0_7FFF_FFFF) begin
							res_q <= 32'sh7FFF_FFFF;
						end else if (sum < -34'sh0_8000_0000) begin
							res_q <= 32'sh8000_0000;
						end else begin
							res_q <= sum[pwl_pkg::DATA_W-1:0];
						end
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: loads when the finished result moves out of S_EMIT.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && slot_free) begin
			rsp_q.result_value <= res_q;
			rsp_q.status       <= st_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The entry count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pwl_pkg::CNT_W'(pwl_pkg::MAX_ENTRIES))
		else $error("entry count exceeds table size");

	// A request transfer is followed by a busy cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> !req_ready)
		else $error("request taken while another is in progress");

	// The scan index stays inside the populated part of the table.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_SCAN) |-> (pwl_pkg::CNT_W'(i_q) < count_q && i_q != '0))
		else $error("scan index out of range");

	// An insert step never reads below the bottom entry.
	a_insert_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_RD) |-> (j_q != '0))
		else $error("insert shift past bottom entry");

endmodule

// ----- tb/tb.sv -----
module tb;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 11;
	localparam int RANDOM_ITEMS  = 1600;
	localparam int STALL_CYCLES  = 300;
	localparam int DRAIN_CYCLES  = 120;
	localparam int WATCHDOG_MAX  = 3000;
	localparam int REPORT_LIMIT  = 10;

	localparam logic signed [pwl_pkg::DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [pwl_pkg::DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	// Clock, reset and the two channels.
	logic              clk = 1'b0;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	pwl_pkg::pwl_req_t req;
	logic              rsp_valid;
	logic              rsp_ready;
	pwl_pkg::pwl_rsp_t rsp;

	always #HALF_PERIOD clk = ~clk;

	piecewise_linear_lookup_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Shadow copy of the breakpoint table, updated on every request transfer.
	logic signed [pwl_pkg::DATA_W-1:0] tbl_key [pwl_pkg::MAX_ENTRIES];
	logic signed [pwl_pkg::DATA_W-1:0] tbl_val [pwl_pkg::MAX_ENTRIES];
	int                                tbl_count = 0;

	// Responses still owed by the block, oldest first.
	pwl_pkg::pwl_rsp_t lookup_rsp_q [$];

	int  req_count    = 0;
	int  error_count  = 0;
	int  rsp_hold_len = 0;
	bit  no_idle      = 1'b0;

	// Interpolate between the bracketing breakpoints, or clamp at the table ends.
	function automatic logic signed [pwl_pkg::DATA_W-1:0] interp_value(
			logic signed [pwl_pkg::DATA_W-1:0] q);
		int          i;
		longint      k0, k1, v0, v1, r, ql;
		logic [63:0] dq, den, dv, quot;
		bit          neg;
		if (q <= tbl_key[0])
			return tbl_val[0];
		if (q >= tbl_key[tbl_count-1])
			return tbl_val[tbl_count-1];
		i = 1;
		while (i < tbl_count - 1 && q > tbl_key[i])
			i++;
		k0 = tbl_key[i-1];
		k1 = tbl_key[i];
		v0 = tbl_val[i-1];
		v1 = tbl_val[i];
		ql = q;
		dq = ql - k0;
		den = k1 - k0;
		neg = v1 < v0;
		dv = neg ? v0 - v1 : v1 - v0;
		quot = (dq * dv) / den;
		r = neg ? v0 - longint'(quot) : v0 + longint'(quot);
		if (r > longint'(KEY_MAX))
			r = KEY_MAX;
		if (r < longint'(KEY_MIN))
			r = KEY_MIN;
		return r[pwl_pkg::DATA_W-1:0];
	endfunction

	// Apply one request to the shadow table and return the response it must produce.
	function automatic pwl_pkg::pwl_rsp_t predict_lookup(pwl_pkg::pwl_req_t item);
		pwl_pkg::pwl_rsp_t rsp_next;
		int                pos;
		rsp_next.result_value = '0;
		rsp_next.status       = pwl_pkg::ST_OK;
		unique case (item.op)
			pwl_pkg::OP_CLEAR: begin
				tbl_count = 0;
			end
			pwl_pkg::OP_INSERT: begin
				if (tbl_count >= pwl_pkg::MAX_ENTRIES) begin
					rsp_next.status = pwl_pkg::ST_FULL;
				end else begin
					// Equal keys stay in arrival order: the new pair goes after them.
					pos = 0;
					while (pos < tbl_count && tbl_key[pos] <= item.key_in)
						pos++;
					for (int j = tbl_count; j > pos; j--) begin
						tbl_key[j] = tbl_key[j-1];
						tbl_val[j] = tbl_val[j-1];
					end
					tbl_key[pos] = item.key_in;
					tbl_val[pos] = item.value_in;
					tbl_count++;
				end
			end
			pwl_pkg::OP_QUERY: begin
				if (tbl_count == 0)
					rsp_next.status = pwl_pkg::ST_EMPTY;
				else
					rsp_next.result_value = interp_value(item.key_in);
			end
			default: ;
		endcase
		return rsp_next;
	endfunction

	// Key generators: full range, a coarse grid that makes ties, and a narrow band.
	function automatic logic signed [pwl_pkg::DATA_W-1:0] draw_key(int style);
		int t;
		unique case (style)
			0: return $urandom;
			1: begin
				t = $urandom_range(0, 16);
				return (t - 8) * 65536;
			end
			default: begin
				t = $urandom_range(0, 1 << 20);
				return t - (1 << 19);
			end
		endcase
	endfunction

	function automatic logic signed [pwl_pkg::DATA_W-1:0] draw_value();
		int t;
		if ($urandom_range(0, 1) == 0)
			return $urandom;
		t = $urandom_range(0, 131072);
		return (t - 65536) * 64;
	endfunction

	// Query keys lean on the current table: exact hits, just outside, and in between.
	function automatic logic signed [pwl_pkg::DATA_W-1:0] draw_query(int style);
		int     sel, i;
		longint span, off;
		sel = $urandom_range(0, 9);
		if (tbl_count == 0 || sel < 2)
			return draw_key(style);
		i = $urandom_range(0, tbl_count - 1);
		if (sel < 4)
			return tbl_key[i];
		if (sel == 4)
			return tbl_key[0] - 32'sd1;
		if (sel == 5)
			return tbl_key[tbl_count-1] + 32'sd1;
		if (i + 1 >= tbl_count)
			return draw_key(style);
		span = longint'(tbl_key[i+1]) - longint'(tbl_key[i]);
		off = $urandom;
		off = off % (span + 1);
		return 32'(longint'(tbl_key[i]) + off);
	endfunction

	// Offer one request and record the response it must produce once it transfers.
	task automatic send_req(logic [1:0] op, logic signed [pwl_pkg::DATA_W-1:0] key,
			logic signed [pwl_pkg::DATA_W-1:0] val);
		pwl_pkg::pwl_req_t item;
		pwl_pkg::pwl_rsp_t predicted;
		int                gap;
		item.op       = op;
		item.key_in   = key;
		item.value_in = val;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predicted = predict_lookup(item);
		lookup_rsp_q = {lookup_rsp_q, predicted};
		req_count++;
		@(negedge clk);
	endtask

	// Empty table, the unused op code, a single entry, extreme keys and tied keys.
	task automatic test_directed_cases();
		send_req(pwl_pkg::OP_QUERY, 32'sd0, 32'sd0);
		send_req(pwl_pkg::OP_NOP, KEY_MAX, KEY_MIN);
		send_req(pwl_pkg::OP_CLEAR, KEY_MIN, KEY_MAX);
		send_req(pwl_pkg::OP_QUERY, KEY_MAX, KEY_MAX);
		send_req(pwl_pkg::OP_INSERT, 32'sd0, 32'sh0064_0000);
		send_req(pwl_pkg::OP_QUERY, KEY_MIN, 32'sd0);
		send_req(pwl_pkg::OP_QUERY, KEY_MAX, 32'sd0);
		send_req(pwl_pkg::OP_INSERT, KEY_MIN, KEY_MIN);
		send_req(pwl_pkg::OP_INSERT, KEY_MAX, KEY_MAX);
		send_req(pwl_pkg::OP_QUERY, -32'sd1, 32'sd0);
		send_req(pwl_pkg::OP_QUERY, KEY_MIN + 32'sd1, 32'sd0);
		send_req(pwl_pkg::OP_QUERY, KEY_MAX - 32'sd1, 32'sd0);
		send_req(pwl_pkg::OP_INSERT, 32'sd0, 32'shFFFB_0000);
		send_req(pwl_pkg::OP_QUERY, 32'sd0, 32'sd0);
		send_req(pwl_pkg::OP_QUERY, 32'sd1, 32'sd0);
		send_req(pwl_pkg::OP_NOP, 32'sd0, 32'sd0);
		send_req(pwl_pkg::OP_CLEAR, 32'sd0, 32'sd0);
		send_req(pwl_pkg::OP_QUERY, 32'sd0, 32'sd0);
	endtask

	// Fill the table to capacity, then insert into the full table and query it.
	task automatic test_table_full();
		send_req(pwl_pkg::OP_CLEAR, $urandom, $urandom);
		repeat (pwl_pkg::MAX_ENTRIES) send_req(pwl_pkg::OP_INSERT, draw_key(1), draw_value());
		repeat (2) send_req(pwl_pkg::OP_INSERT, draw_key(0), draw_value());
		repeat (6) send_req(pwl_pkg::OP_QUERY, draw_query(1), $urandom);
	endtask

	// Hold the response side for a long stretch while requests keep coming.
	task automatic test_output_stall();
		send_req(pwl_pkg::OP_CLEAR, $urandom, $urandom);
		repeat (5) send_req(pwl_pkg::OP_INSERT, draw_key(2), draw_value());
		no_idle      = 1'b1;
		rsp_hold_len = STALL_CYCLES;
		repeat (10) send_req(pwl_pkg::OP_QUERY, draw_query(2), $urandom);
		no_idle = 1'b0;
	endtask

	// Mostly well-formed sessions of clear, inserts and queries; some noise.
	task automatic test_random_sequences(int n_items);
		int last, style, n_ins;
		last = req_count + n_items;
		while (req_count < last) begin
			no_idle = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 4))
					send_req(2'($urandom_range(0, 3)), $urandom, $urandom);
			end else begin
				style = $urandom_range(0, 2);
				if ($urandom_range(0, 4) != 0)
					send_req(pwl_pkg::OP_CLEAR, $urandom, $urandom);
				n_ins = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 19)
					: $urandom_range(1, 6);
				repeat (n_ins) begin
					send_req(pwl_pkg::OP_INSERT, draw_key(style), draw_value());
					if ($urandom_range(0, 3) == 0)
						send_req(pwl_pkg::OP_QUERY, draw_query(style), $urandom);
				end
				repeat ($urandom_range(2, 8))
					send_req(pwl_pkg::OP_QUERY, draw_query(style), $urandom);
			end
		end
		no_idle = 1'b0;
	endtask

	// Response side: a random pause per transfer, none while no_idle is set, or a long hold when one is requested.
	initial begin : rsp_sink
		int stall;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold_len > 0) begin
				stall = rsp_hold_len;
				rsp_hold_len = 0;
			end else if (no_idle) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 7);
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// Compare every response transfer against the oldest outstanding prediction.
	always @(posedge clk) begin : rsp_checker
		pwl_pkg::pwl_rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (lookup_rsp_q.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("Unexpected response: value %0d status %0d",
						rsp.result_value, rsp.status);
			end else begin
				want = lookup_rsp_q.pop_front();
				if (rsp.result_value !== want.result_value || rsp.status !== want.status) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("Mismatch: expected %0d status %0d, got %0d status %0d",
							want.result_value, want.status, rsp.result_value, rsp.status);
				end
			end
		end
	end

	// Stop the run if neither channel completes a transfer for too long.
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end else begin
			quiet_cycles = 0;
		end
	end

	// Test sequence.
	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_table_full();
		test_output_stall();
		test_random_sequences(RANDOM_ITEMS);
		req_valid <= 1'b0;

		while (lookup_rsp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
